// ===== hw/rtl/rs485_sum16_frame_engine_assert.svh =====
// Assertion macros for the RS485 sum16 frame engine.
`ifndef RS485_SUM16_FRAME_ENGINE_ASSERT_SVH
`define RS485_SUM16_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsf assertion failed");

// Next-cycle implication, disabled during reset.
`define RSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsf assertion failed");

`endif

// ===== hw/rtl/rsf_pkg.sv =====
// Shared types and constants for the RS485 sum16 frame engine.
`timescale 1ns / 1ps

package rsf_pkg;

    localparam int DEF_PAYLOAD_BYTES = 14;
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 64;
    localparam logic [15:0] HOLD_TICKS_RESET = 16'd10;

    // input operations (s_axis_tuser)
    localparam logic [1:0] OP_TX   = 2'd0;
    localparam logic [1:0] OP_RX   = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // result kinds (m_axis_tuser)
    localparam logic [1:0] KIND_LINE   = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SEND = 3'b010,
        PH_HOLD = 3'b100
    } tx_phase_t;

    // what the results of the current word look like
    typedef enum logic [4:0] {
        PLAN_STATUS  = 5'b00001,
        PLAN_ERROR   = 5'b00010,
        PLAN_TX1     = 5'b00100,
        PLAN_TX3     = 5'b01000,
        PLAN_RELEASE = 5'b10000
    } plan_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic load;
    } rsf_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic last_result;
    } rsf_status_t;

endpackage

// ===== hw/rtl/rs485_sum16_frame_engine.sv =====
// Top level of the RS485 sum16 framer/deframer: controller plus datapath.
`timescale 1ns / 1ps

// Half-duplex framer/deframer for frames of PAYLOAD_BYTES payload bytes plus a
// 16-bit byte sum, high byte first. Each input word is first accepted, which
// updates state, and then its results are loaded into the output register, one
// per cycle while the output register is free. A transmit word that closes a
// frame gives three results and a received byte that completes a good frame
// gives PAYLOAD_BYTES + 2 results. A new word is accepted while the last result
// of the previous word waits in the output register. The user writes hold_ticks
// through cfg_wr_en/cfg_wr_data only while the block is idle; the block itself
// does not enforce this. No clearing pass runs after reset.

`include "rs485_sum16_frame_engine_assert.svh"

module rs485_sum16_frame_engine
    import rsf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,    // hold_ticks
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]           s_axis_tuser,   // [1:0] operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] byte_value, [8] drive_enable, [9] tx_busy, [25:10] ok_count,
    // [41:26] ng_count, [57:42] total_count, [63:58] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]           m_axis_tuser,   // [1:0] kind
    output logic                 m_axis_tlast
);

    rsf_cmd_t    cmd;
    rsf_status_t status;

    rsf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    rsf_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

    // one word at a time: no accept on the cycle after an accept
    `RSF_ASSERT_NEXT(a_one_word, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a checksum error is always the only, hence last, result of its word
    `RSF_ASSERT_NOW(a_err_last, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_ERROR), m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    // status results carry no byte and close their word
    `RSF_ASSERT_NOW(a_status_last, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_STATUS), m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    // busy and driver enable track the same phase
    `RSF_ASSERT_NOW(a_busy_drive, aclk, aresetn, m_axis_tvalid, m_axis_tdata[8] == m_axis_tdata[9])

endmodule

// ===== hw/rtl/rsf_ctrl.sv =====
// Controller FSM: accepts one word, then loads its results one per cycle while the output slot is free.
`timescale 1ns / 1ps

module rsf_ctrl
    import rsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  rsf_status_t status,
    output rsf_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_axis_tvalid;
                if (s_axis_tvalid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.load = status.slot_free;
                if (status.slot_free && status.last_result) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/rsf_datapath.sv =====
// Datapath: tx/rx framing state, frame buffer, counters and output register.
`timescale 1ns / 1ps

module rsf_datapath
    import rsf_pkg::*;
#(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    input  rsf_cmd_t             cmd,
    output rsf_status_t          status
);

    localparam int FRAME_LEN = PAYLOAD_BYTES + 2;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int TXI_W     = $clog2(PAYLOAD_BYTES + 1);

    logic [7:0] in_byte;
    logic [1:0] in_op;
    assign in_byte = s_axis_tdata[7:0];
    assign in_op   = s_axis_tuser;

    logic [15:0]      hold_ticks_reg, hold_ticks_next;
    tx_phase_t        tx_phase_reg, tx_phase_next;
    logic [TXI_W-1:0] tx_index_reg, tx_index_next;
    logic [15:0]      tx_sum_reg, tx_sum_next;
    logic [15:0]      hold_timer_reg, hold_timer_next;
    logic [IDX_W-1:0] rx_index_reg, rx_index_next;
    logic [15:0]      rx_sum_reg, rx_sum_next;
    logic [15:0]      ok_cnt_reg, ok_cnt_next;
    logic [15:0]      ng_cnt_reg, ng_cnt_next;
    logic [15:0]      total_cnt_reg, total_cnt_next;
    plan_t            plan_reg, plan_next;
    logic [IDX_W-1:0] seq_reg, seq_next;
    logic [7:0]       tx_b_reg, tx_b_next;
    logic [7:0]       tx_hi_reg, tx_hi_next;
    logic [7:0]       tx_lo_reg, tx_lo_next;
    logic [7:0]       chk_hi_reg, chk_hi_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_drive_reg, out_drive_next;
    logic [15:0]      out_ok_reg, out_ok_next;
    logic [15:0]      out_ng_reg, out_ng_next;
    logic [15:0]      out_total_reg, out_total_next;

    logic [7:0]       frame_mem [FRAME_LEN];
    logic [7:0]       rd_data_reg;
    logic             mem_wr;

    logic [15:0]      tx_sum_add;
    logic             rx_good;
    logic             res_last;
    logic [1:0]       res_kind;
    logic [7:0]       res_byte;

    assign tx_sum_add = tx_sum_reg + {8'd0, in_byte};
    assign rx_good    = (chk_hi_reg == rx_sum_reg[15:8]) && (in_byte == rx_sum_reg[7:0]);
    assign mem_wr     = cmd.accept && (in_op == OP_RX);

    // per-word state update at the accept edge; hold_ticks follows cfg_wr_en instead
    always_comb begin
        hold_ticks_next = cfg_wr_en ? cfg_wr_data : hold_ticks_reg;
        tx_phase_next   = tx_phase_reg;
        tx_index_next   = tx_index_reg;
        tx_sum_next     = tx_sum_reg;
        hold_timer_next = hold_timer_reg;
        rx_index_next   = rx_index_reg;
        rx_sum_next     = rx_sum_reg;
        ok_cnt_next     = ok_cnt_reg;
        ng_cnt_next     = ng_cnt_reg;
        total_cnt_next  = total_cnt_reg;
        plan_next       = plan_reg;
        tx_b_next       = tx_b_reg;
        tx_hi_next      = tx_hi_reg;
        tx_lo_next      = tx_lo_reg;
        chk_hi_next     = chk_hi_reg;
        if (cmd.accept) begin
            plan_next = PLAN_STATUS;
            if (in_op == OP_TX && tx_phase_reg != PH_HOLD) begin
                tx_b_next = in_byte;
                if (tx_index_reg == TXI_W'(PAYLOAD_BYTES - 1)) begin
                    tx_hi_next      = tx_sum_add[15:8];
                    tx_lo_next      = tx_sum_add[7:0];
                    tx_phase_next   = PH_HOLD;
                    tx_index_next   = '0;
                    tx_sum_next     = '0;
                    hold_timer_next = '0;
                    plan_next       = PLAN_TX3;
                end else begin
                    tx_phase_next = PH_SEND;
                    tx_index_next = tx_index_reg + 1'b1;
                    tx_sum_next   = tx_sum_add;
                    plan_next     = PLAN_TX1;
                end
            end else if (in_op == OP_RX) begin
                if (rx_index_reg < IDX_W'(PAYLOAD_BYTES)) begin
                    rx_sum_next = rx_sum_reg + {8'd0, in_byte};
                end
                if (rx_index_reg == IDX_W'(PAYLOAD_BYTES)) begin
                    chk_hi_next = in_byte;
                end
                if (rx_index_reg == IDX_W'(FRAME_LEN - 1)) begin
                    total_cnt_next = total_cnt_reg + 16'd1;
                    if (rx_good) begin
                        ok_cnt_next = ok_cnt_reg + 16'd1;
                        plan_next   = PLAN_RELEASE;
                    end else begin
                        ng_cnt_next = ng_cnt_reg + 16'd1;
                        plan_next   = PLAN_ERROR;
                    end
                    rx_index_next = '0;
                    rx_sum_next   = '0;
                end else begin
                    rx_index_next = rx_index_reg + 1'b1;
                end
            end else if (in_op == OP_TICK && tx_phase_reg == PH_HOLD) begin
                // releases on the tick that makes elapsed ticks exceed hold_ticks
                if (hold_timer_reg >= hold_ticks_reg) begin
                    tx_phase_next   = PH_IDLE;
                    hold_timer_next = '0;
                end else begin
                    hold_timer_next = hold_timer_reg + 16'd1;
                end
            end
        end
    end

    // result selection for the current sequence position
    always_comb begin
        res_last = 1'b1;
        res_kind = KIND_STATUS;
        res_byte = 8'd0;
        unique case (plan_reg)
            PLAN_STATUS: begin
                res_kind = KIND_STATUS;
            end
            PLAN_ERROR: begin
                res_kind = KIND_ERROR;
            end
            PLAN_TX1: begin
                res_kind = KIND_LINE;
                res_byte = tx_b_reg;
            end
            PLAN_TX3: begin
                res_kind = KIND_LINE;
                res_last = (seq_reg == IDX_W'(2));
                if (seq_reg == '0) begin
                    res_byte = tx_b_reg;
                end else if (seq_reg == IDX_W'(1)) begin
                    res_byte = tx_hi_reg;
                end else begin
                    res_byte = tx_lo_reg;
                end
            end
            PLAN_RELEASE: begin
                res_kind = KIND_FRAME;
                res_byte = rd_data_reg;
                res_last = (seq_reg == IDX_W'(FRAME_LEN - 1));
            end
            default: begin
                res_kind = KIND_STATUS;
            end
        endcase
    end

    assign status.slot_free   = !out_valid_reg || m_axis_tready;
    assign status.last_result = res_last;

    // sequence counter doubles as the frame buffer read address
    always_comb begin
        seq_next = seq_reg;
        if (cmd.accept) begin
            seq_next = '0;
        end else if (cmd.load) begin
            seq_next = seq_reg + 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_drive_next = out_drive_reg;
        out_ok_next    = out_ok_reg;
        out_ng_next    = out_ng_reg;
        out_total_next = out_total_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind;
            out_byte_next  = res_byte;
            out_last_next  = res_last;
            out_drive_next = (tx_phase_reg != PH_IDLE);
            out_ok_next    = ok_cnt_reg;
            out_ng_next    = ng_cnt_reg;
            out_total_next = total_cnt_reg;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= HOLD_TICKS_RESET;
            tx_phase_reg   <= PH_IDLE;
            tx_index_reg   <= '0;
            tx_sum_reg     <= '0;
            hold_timer_reg <= '0;
            rx_index_reg   <= '0;
            rx_sum_reg     <= '0;
            ok_cnt_reg     <= '0;
            ng_cnt_reg     <= '0;
            total_cnt_reg  <= '0;
            plan_reg       <= PLAN_STATUS;
            seq_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_ticks_reg <= hold_ticks_next;
            tx_phase_reg   <= tx_phase_next;
            tx_index_reg   <= tx_index_next;
            tx_sum_reg     <= tx_sum_next;
            hold_timer_reg <= hold_timer_next;
            rx_index_reg   <= rx_index_next;
            rx_sum_reg     <= rx_sum_next;
            ok_cnt_reg     <= ok_cnt_next;
            ng_cnt_reg     <= ng_cnt_next;
            total_cnt_reg  <= total_cnt_next;
            plan_reg       <= plan_next;
            seq_reg        <= seq_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tx_b_reg      <= tx_b_next;
        tx_hi_reg     <= tx_hi_next;
        tx_lo_reg     <= tx_lo_next;
        chk_hi_reg    <= chk_hi_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_drive_reg <= out_drive_next;
        out_ok_reg    <= out_ok_next;
        out_ng_reg    <= out_ng_next;
        out_total_reg <= out_total_next;
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            frame_mem[rx_index_reg] <= in_byte;
        end
        rd_data_reg <= frame_mem[seq_next];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_total_reg, out_ng_reg, out_ok_reg,
                            out_drive_reg, out_drive_reg, out_byte_reg};

endmodule

// ===== verif/tb_rs485_sum16_frame_engine.sv =====
// Self-checking testbench for rs485_sum16_frame_engine: random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb_rs485_sum16_frame_engine;
    import rsf_pkg::*;

    localparam int PAYLOAD = DEF_PAYLOAD_BYTES;
    localparam int FRAME   = PAYLOAD + 2;
    localparam int GAP_PCT = 29;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] TX_PATTERN [PAYLOAD] = '{
        8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55,
        8'hAA, 8'hFF, 8'hFF, 8'h0F, 8'hF0, 8'h33, 8'hCC
    };

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic        last;
        logic        drive_en;
        logic        busy;
        logic [15:0] ok_cnt;
        logic [15:0] ng_cnt;
        logic [15:0] total_cnt;
    } line_word_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [15:0]          cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    rs485_sum16_frame_engine u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // predictor state
    tx_phase_t   tx_state;
    int          tx_count;
    logic [15:0] tx_acc;
    logic [15:0] hold_count;
    logic [15:0] hold_limit;
    int          rx_count;
    logic [15:0] rx_acc;
    logic [7:0]  rx_buf [FRAME];
    logic [15:0] cnt_ok;
    logic [15:0] cnt_ng;
    logic [15:0] cnt_total;

    line_word_t  due_words[$];
    int          mismatches    = 0;
    int          items_done    = 0;
    int          hold_off_left = 0;
    bit          gaps_on       = 1'b1;

    function automatic void clear_prediction();
        tx_state   = PH_IDLE;
        tx_count   = 0;
        tx_acc     = '0;
        hold_count = '0;
        hold_limit = HOLD_TICKS_RESET;
        rx_count   = 0;
        rx_acc     = '0;
        cnt_ok     = '0;
        cnt_ng     = '0;
        cnt_total  = '0;
        due_words.delete();
    endfunction

    function automatic void queue_word(logic [1:0] kind, logic [7:0] val);
        line_word_t w;
        w.kind       = kind;
        w.byte_value = val;
        w.last       = 1'b0;
        w.drive_en   = (tx_state != PH_IDLE);
        w.busy       = (tx_state != PH_IDLE);
        w.ok_cnt     = cnt_ok;
        w.ng_cnt     = cnt_ng;
        w.total_cnt  = cnt_total;
        due_words.push_back(w);
    endfunction

    // Returns 1 when the word changes framer state.
    function automatic bit compute_frame_outputs(logic [1:0] op, logic [7:0] b);
        bit   effect;
        logic good;
        int   i;
        effect = 1'b1;
        if (op == OP_TX && tx_state != PH_HOLD) begin
            tx_state = PH_SEND;
            tx_acc   = tx_acc + b;
            queue_word(KIND_LINE, b);
            tx_count++;
            if (tx_count >= PAYLOAD) begin
                queue_word(KIND_LINE, tx_acc[15:8]);
                queue_word(KIND_LINE, tx_acc[7:0]);
                tx_state   = PH_HOLD;
                tx_count   = 0;
                tx_acc     = '0;
                hold_count = '0;
            end
        end else if (op == OP_RX) begin
            rx_buf[rx_count] = b;
            if (rx_count < PAYLOAD)
                rx_acc = rx_acc + b;
            rx_count++;
            if (rx_count >= FRAME) begin
                good = (rx_buf[PAYLOAD] == rx_acc[15:8]) &&
                       (rx_buf[PAYLOAD+1] == rx_acc[7:0]);
                cnt_total++;
                if (good) begin
                    cnt_ok++;
                    for (i = 0; i < FRAME; i++)
                        queue_word(KIND_FRAME, rx_buf[i]);
                end else begin
                    cnt_ng++;
                    queue_word(KIND_ERROR, 8'h00);
                end
                rx_count = 0;
                rx_acc   = '0;
            end else begin
                queue_word(KIND_STATUS, 8'h00);
            end
        end else begin
            effect = 1'b0;
            if (op == OP_TICK && tx_state == PH_HOLD) begin
                effect = 1'b1;
                // release on the tick after the timer has reached the limit
                if (hold_count >= hold_limit) begin
                    tx_state   = PH_IDLE;
                    hold_count = '0;
                end else begin
                    hold_count++;
                end
            end
            queue_word(KIND_STATUS, 8'h00);
        end
        due_words[due_words.size()-1].last = 1'b1;
        return effect;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : check_words
        line_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (due_words.size() == 0) begin
                $error("unexpected word: tuser 0x%0h tdata 0x%0h", m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = due_words.pop_front();
                check_field("kind", want.kind, m_axis_tuser);
                check_field("byte_value", want.byte_value, m_axis_tdata[7:0]);
                check_field("last", want.last, m_axis_tlast);
                check_field("drive_enable", want.drive_en, m_axis_tdata[8]);
                check_field("tx_busy", want.busy, m_axis_tdata[9]);
                check_field("ok_count", want.ok_cnt, m_axis_tdata[25:10]);
                check_field("ng_count", want.ng_cnt, m_axis_tdata[41:26]);
                check_field("total_count", want.total_cnt, m_axis_tdata[57:42]);
                check_field("tdata pad", '0, m_axis_tdata[63:58]);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_off_left--;
        end else if (gaps_on) begin
            m_axis_tready <= ($urandom_range(0, 99) >= GAP_PCT);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // tvalid stays high after acceptance; anything that lets time pass lowers it first
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < GAP_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (compute_frame_outputs(op, b))
            items_done++;
    endtask

    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_hold_ticks(input logic [15:0] value);
        drain_words();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        hold_limit = value;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_noise(input bit allow_rx);
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (!allow_rx && op == OP_RX)
            op = OP_UNUSED;
        send_word(op, pick_byte());
    endtask

    task automatic send_rx_frame(input bit corrupt);
        logic [7:0]  frame_bytes [FRAME];
        logic [15:0] sum;
        int          i;
        int          pos;
        int          fill;
        // finish any partial frame first so the next one lines up
        while (rx_count != 0)
            send_word(OP_RX, pick_byte());
        fill = $urandom_range(0, 7);
        sum  = '0;
        for (i = 0; i < PAYLOAD; i++) begin
            frame_bytes[i] = (fill == 0) ? 8'hFF : (fill == 1) ? 8'h00 : pick_byte();
            sum = sum + frame_bytes[i];
        end
        frame_bytes[PAYLOAD]   = sum[15:8];
        frame_bytes[PAYLOAD+1] = sum[7:0];
        if (corrupt) begin
            pos = $urandom_range(0, FRAME - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        for (i = 0; i < FRAME; i++) begin
            if ($urandom_range(0, 99) < 10)
                send_noise(1'b0);
            send_word(OP_RX, frame_bytes[i]);
        end
    endtask

    // full transmit frame, then ticks until the driver lets go
    task automatic send_tx_frame();
        while (tx_state == PH_HOLD)
            send_word(OP_TICK, pick_byte());
        do begin
            if ($urandom_range(0, 99) < 10)
                send_word(OP_RX, pick_byte());
            send_word(OP_TX, pick_byte());
        end while (tx_state != PH_HOLD);
        while (tx_state == PH_HOLD) begin
            if ($urandom_range(0, 99) < 10)
                send_word(OP_TX, pick_byte());
            send_word(OP_TICK, pick_byte());
        end
    endtask

    task automatic run_random_mix(input int count);
        int stop;
        int sel;
        int i;
        stop = items_done + count;
        while (items_done < stop) begin
            if ($urandom_range(0, 7) == 0)
                write_hold_ticks(16'($urandom_range(0, 6)));
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_rx_frame(1'b0);
            else if (sel < 60)
                send_rx_frame(1'b1);
            else if (sel < 85)
                send_tx_frame();
            else
                for (i = 0; i < $urandom_range(1, 4); i++)
                    send_noise(1'b1);
        end
    endtask

    task automatic test_idle_specials();
        send_word(OP_TICK, 8'hA5);
        send_word(OP_UNUSED, 8'hFF);
        send_word(OP_UNUSED, 8'h00);
    endtask

    // transmit frame with receive bytes mixed in, then hold with a zero limit
    task automatic test_tx_with_rx();
        int i;
        write_hold_ticks(16'd0);
        for (i = 0; i < PAYLOAD; i++) begin
            send_word(OP_TX, TX_PATTERN[i]);
            if (i % 2 == 0)
                send_word(OP_RX, pick_byte());
        end
        send_word(OP_TX, 8'h5A);    // dropped: still holding
        send_word(OP_TICK, 8'h00);  // releases at once
    endtask

    // largest limit, then cut it down while the hold is running
    task automatic test_hold_extremes();
        int i;
        write_hold_ticks(16'hFFFF);
        for (i = 0; i < PAYLOAD; i++)
            send_word(OP_TX, pick_byte());
        repeat (3) send_word(OP_TICK, 8'hFF);
        write_hold_ticks(16'd1);
        send_word(OP_TICK, 8'h00);
    endtask

    task automatic test_random_frames();
        run_random_mix(200);
    endtask

    task automatic test_backpressure();
        drain_words();
        hold_off_left = 300;
        run_random_mix(40);
    endtask

    task automatic test_streaming();
        drain_words();
        gaps_on = 1'b0;
        run_random_mix(40);
        drain_words();
        gaps_on = 1'b1;
    endtask

    initial begin
        clear_prediction();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_specials();
        test_tx_with_rx();
        test_hold_extremes();
        test_random_frames();
        test_backpressure();
        test_streaming();
        drain_words();
        repeat (FRAME + 4) @(posedge aclk);
        if (mismatches == 0 && due_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
